### rtl/core/cta_pkg.sv
// ----------------------------------------------------------------------------
// cta_pkg
// Shared types and constants for the cube map texel address pipeline.
// ----------------------------------------------------------------------------
package cta_pkg;

	localparam int DIR_W          = 16;
	localparam int CFG_W          = 13;
	localparam int FACE_W         = 3;
	localparam int TEXEL_W        = 12;
	localparam int ELEM_W         = 26;
	localparam int MAX_FACE_SIZE  = 4096;

	localparam logic [CFG_W-1:0]  FACE_SIZE_RST = CFG_W'(256);

	localparam logic [FACE_W-1:0] FACE_POS_X = 3'd0;
	localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd1;
	localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd2;
	localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd3;
	localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd4;
	localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd5;

	typedef struct packed {
		logic signed [DIR_W-1:0] dir_x;
		logic signed [DIR_W-1:0] dir_y;
		logic signed [DIR_W-1:0] dir_z;
	} dir_t;

	typedef struct packed {
		logic [FACE_W-1:0]  face_index;
		logic [TEXEL_W-1:0] texel_col;
		logic [TEXEL_W-1:0] texel_row;
		logic [ELEM_W-1:0]  element_index;
		logic               zero_vector;
	} texel_t;

endpackage

### rtl/core/cubemap_texel_address.sv
// ----------------------------------------------------------------------------
// cubemap_texel_address
// Cube map face selection and texel addressing from a Q2.14 direction.
//
// Usage:
//   in_*   : one direction (dir_x, dir_y, dir_z) per transfer.
//   out_*  : one result per direction, in order: face, texel column/row,
//            first RGB element index, zero-vector flag.
//   cfg_*  : face_size write; always ready. Write it only while idle.
// Timing:
//   The two texel quotients come from a restoring divider that resolves one
//   quotient bit per stage, which sets the pipeline depth. Throughput is one
//   transfer per cycle while out_ready stays high.
// Stall:
//   Each stage advances when it is empty or its successor advances, so
//   bubbles collapse and inputs keep flowing while a result waits on
//   out_ready. in_ready drops only when every stage holds an item.
// Reset:
//   arst_n clears all valid bits and sets face_size to 256.
// ----------------------------------------------------------------------------
module cubemap_texel_address #(
	parameter int MAX_FACE_SIZE = cta_pkg::MAX_FACE_SIZE
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  cta_pkg::dir_t             in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output cta_pkg::texel_t           out_data,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [cta_pkg::CFG_W-1:0] cfg_data
);

	localparam int SZW = $clog2(MAX_FACE_SIZE + 1);
	localparam int QW  = SZW;
	localparam int NW  = 17 + SZW;
	localparam int PW  = 2 * SZW;
	localparam int EW  = PW + 2;

	function automatic logic [17:0] div_step(input logic [16:0] rem, input logic nb,
			input logic [16:0] den);
		logic [17:0] r;
		logic        ge;
		r  = {rem, nb};
		ge = (r >= {1'b0, den});
		return {ge, ge ? 17'(r - {1'b0, den}) : r[16:0]};
	endfunction

	// configuration
	logic [cta_pkg::CFG_W-1:0] face_size_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_size_q <= cta_pkg::FACE_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			face_size_q <= cfg_data;
		end
	end

	// stage enables
	logic          vld_s1, vld_s2, vld_s3, vld_s5, vld_s6, vld_s7;
	logic [QW-1:0] vld_s4;
	logic          en1, en2, en3, en5, en6, en7;
	logic [QW-1:0] en4;

	assign en7 = !vld_s7 || out_ready;
	assign en6 = !vld_s6 || en7;
	assign en5 = !vld_s5 || en6;

	always_comb begin
		en4[QW-1] = !vld_s4[QW-1] || en5;
		for (int j = QW - 2; j >= 0; j--) begin
			en4[j] = !vld_s4[j] || en4[j+1];
		end
	end

	assign en3 = !vld_s3 || en4[0];
	assign en2 = !vld_s2 || en3;
	assign en1 = !vld_s1 || en2;
	assign in_ready = en1;

	// stage 1: major axis, face, u/v, size clamp
	logic [15:0]                ax, ay, az;
	logic signed [16:0]         x17, y17, z17;
	logic [cta_pkg::FACE_W-1:0] face_c;
	logic signed [16:0]         u_c, v_c;
	logic [15:0]                ma_c;
	logic                       zero_c;
	logic [SZW-1:0]             size_c;

	always_comb begin
		x17 = {in_data.dir_x[15], in_data.dir_x};
		y17 = {in_data.dir_y[15], in_data.dir_y};
		z17 = {in_data.dir_z[15], in_data.dir_z};
		ax  = in_data.dir_x[15] ? 16'(-in_data.dir_x) : in_data.dir_x;
		ay  = in_data.dir_y[15] ? 16'(-in_data.dir_y) : in_data.dir_y;
		az  = in_data.dir_z[15] ? 16'(-in_data.dir_z) : in_data.dir_z;
		zero_c = (in_data.dir_x == '0) && (in_data.dir_y == '0) && (in_data.dir_z == '0);
		if (ax >= ay && ax >= az) begin
			ma_c = ax;
			v_c  = -y17;
			if (in_data.dir_x > 0) begin
				face_c = cta_pkg::FACE_POS_X;
				u_c    = -z17;
			end else begin
				face_c = cta_pkg::FACE_NEG_X;
				u_c    = z17;
			end
		end else if (ay >= az) begin
			ma_c = ay;
			u_c  = x17;
			if (in_data.dir_y > 0) begin
				face_c = cta_pkg::FACE_POS_Y;
				v_c    = z17;
			end else begin
				face_c = cta_pkg::FACE_NEG_Y;
				v_c    = -z17;
			end
		end else begin
			ma_c = az;
			v_c  = -y17;
			if (in_data.dir_z > 0) begin
				face_c = cta_pkg::FACE_POS_Z;
				u_c    = x17;
			end else begin
				face_c = cta_pkg::FACE_NEG_Z;
				u_c    = -x17;
			end
		end
		if (face_size_q == '0) begin
			size_c = SZW'(1);
		end else if (32'(face_size_q) > 32'(MAX_FACE_SIZE)) begin
			size_c = SZW'(MAX_FACE_SIZE);
		end else begin
			size_c = SZW'(face_size_q);
		end
	end

	logic [cta_pkg::FACE_W-1:0] face_s1;
	logic signed [16:0]         u_s1, v_s1;
	logic [15:0]                ma_s1;
	logic                       zero_s1;
	logic [SZW-1:0]             size_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			face_s1 <= face_c;
			u_s1    <= u_c;
			v_s1    <= v_c;
			ma_s1   <= ma_c;
			zero_s1 <= zero_c;
			size_s1 <= size_c;
		end
	end

	// stage 2: offsets w + ma and divisor 2*ma
	logic signed [17:0]         su_c, sv_c;
	logic [16:0]                nu_s2, nv_s2, den_s2;
	logic [cta_pkg::FACE_W-1:0] face_s2;
	logic                       zero_s2;
	logic [SZW-1:0]             size_s2;

	assign su_c = {u_s1[16], u_s1} + $signed({2'b00, ma_s1});
	assign sv_c = {v_s1[16], v_s1} + $signed({2'b00, ma_s1});

	always_ff @(posedge clk) begin
		if (en2) begin
			nu_s2   <= su_c[16:0];
			nv_s2   <= sv_c[16:0];
			den_s2  <= {ma_s1, 1'b0};
			face_s2 <= face_s1;
			zero_s2 <= zero_s1;
			size_s2 <= size_s1;
		end
	end

	// stage 3: scale by face size
	logic [NW-1:0]              pu_s3, pv_s3;
	logic [16:0]                den_s3;
	logic [cta_pkg::FACE_W-1:0] face_s3;
	logic                       zero_s3;
	logic [SZW-1:0]             size_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			pu_s3   <= NW'(nu_s2) * NW'(size_s2);
			pv_s3   <= NW'(nv_s2) * NW'(size_s2);
			den_s3  <= den_s2;
			face_s3 <= face_s2;
			zero_s3 <= zero_s2;
			size_s3 <= size_s2;
		end
	end

	// stage 4: restoring divider, one quotient bit per step
	logic [16:0]                crem_s4 [QW];
	logic [QW-1:0]              clow_s4 [QW];
	logic [QW-1:0]              cq_s4   [QW];
	logic [16:0]                rrem_s4 [QW];
	logic [QW-1:0]              rlow_s4 [QW];
	logic [QW-1:0]              rq_s4   [QW];
	logic [16:0]                den_s4  [QW];
	logic [cta_pkg::FACE_W-1:0] face_s4 [QW];
	logic                       zero_s4 [QW];
	logic [SZW-1:0]             size_s4 [QW];

	for (genvar j = 0; j < QW; j++) begin : g_div
		logic [16:0]                crem_p, rrem_p, den_p;
		logic [QW-1:0]              clow_p, rlow_p, cq_p, rq_p;
		logic [cta_pkg::FACE_W-1:0] face_p;
		logic                       zero_p, vld_p;
		logic [SZW-1:0]             size_p;
		logic [17:0]                cstep, rstep;

		if (j == 0) begin : g_first
			assign crem_p = pu_s3[NW-1:QW];
			assign clow_p = pu_s3[QW-1:0];
			assign cq_p   = '0;
			assign rrem_p = pv_s3[NW-1:QW];
			assign rlow_p = pv_s3[QW-1:0];
			assign rq_p   = '0;
			assign den_p  = den_s3;
			assign face_p = face_s3;
			assign zero_p = zero_s3;
			assign size_p = size_s3;
			assign vld_p  = vld_s3;
		end else begin : g_next
			assign crem_p = crem_s4[j-1];
			assign clow_p = clow_s4[j-1];
			assign cq_p   = cq_s4[j-1];
			assign rrem_p = rrem_s4[j-1];
			assign rlow_p = rlow_s4[j-1];
			assign rq_p   = rq_s4[j-1];
			assign den_p  = den_s4[j-1];
			assign face_p = face_s4[j-1];
			assign zero_p = zero_s4[j-1];
			assign size_p = size_s4[j-1];
			assign vld_p  = vld_s4[j-1];
		end

		assign cstep = div_step(crem_p, clow_p[QW-1], den_p);
		assign rstep = div_step(rrem_p, rlow_p[QW-1], den_p);

		always_ff @(posedge clk) begin
			if (en4[j]) begin
				crem_s4[j] <= cstep[16:0];
				clow_s4[j] <= clow_p << 1;
				cq_s4[j]   <= (cq_p << 1) | QW'(cstep[17]);
				rrem_s4[j] <= rstep[16:0];
				rlow_s4[j] <= rlow_p << 1;
				rq_s4[j]   <= (rq_p << 1) | QW'(rstep[17]);
				den_s4[j]  <= den_p;
				face_s4[j] <= face_p;
				zero_s4[j] <= zero_p;
				size_s4[j] <= size_p;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s4[j] <= 1'b0;
			end else if (en4[j]) begin
				vld_s4[j] <= vld_p;
			end
		end
	end

	// stage 5: clamp to size-1
	logic [SZW-1:0]             lim_c;
	logic [SZW-1:0]             col_s5, row_s5, size_s5;
	logic [cta_pkg::FACE_W-1:0] face_s5;
	logic                       zero_s5;

	assign lim_c = size_s4[QW-1] - SZW'(1);

	always_ff @(posedge clk) begin
		if (en5) begin
			col_s5  <= (zero_s4[QW-1] || cq_s4[QW-1] > lim_c) ? lim_c : cq_s4[QW-1];
			row_s5  <= (zero_s4[QW-1] || rq_s4[QW-1] > lim_c) ? lim_c : rq_s4[QW-1];
			size_s5 <= size_s4[QW-1];
			face_s5 <= face_s4[QW-1];
			zero_s5 <= zero_s4[QW-1];
		end
	end

	// stage 6: row * size
	logic [PW-1:0]              prod_s6;
	logic [SZW-1:0]             col_s6, row_s6;
	logic [cta_pkg::FACE_W-1:0] face_s6;
	logic                       zero_s6;

	always_ff @(posedge clk) begin
		if (en6) begin
			prod_s6 <= PW'(row_s5) * PW'(size_s5);
			col_s6  <= col_s5;
			row_s6  <= row_s5;
			face_s6 <= face_s5;
			zero_s6 <= zero_s5;
		end
	end

	// stage 7: element index, output register
	logic [EW-1:0] lin_c, elem_c;

	assign lin_c  = EW'(prod_s6) + EW'(col_s6);
	assign elem_c = lin_c + (lin_c << 1);

	always_ff @(posedge clk) begin
		if (en7) begin
			out_data.face_index    <= face_s6;
			out_data.texel_col     <= cta_pkg::TEXEL_W'(col_s6);
			out_data.texel_row     <= cta_pkg::TEXEL_W'(row_s6);
			out_data.element_index <= cta_pkg::ELEM_W'(elem_c);
			out_data.zero_vector   <= zero_s6;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else begin
			if (en1) vld_s1 <= in_valid;
			if (en2) vld_s2 <= vld_s1;
			if (en3) vld_s3 <= vld_s2;
			if (en5) vld_s5 <= vld_s4[QW-1];
			if (en6) vld_s6 <= vld_s5;
			if (en7) vld_s7 <= vld_s6;
		end
	end

	assign out_valid = vld_s7;

endmodule

### rtl/core/cta_checker.sv
// ----------------------------------------------------------------------------
// cta_checker
// Port-level checks for cubemap_texel_address, bound to the top level.
// ----------------------------------------------------------------------------
module cta_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input cta_pkg::dir_t             in_data,
	input logic                      out_valid,
	input logic                      out_ready,
	input cta_pkg::texel_t           out_data,
	input logic                      cfg_valid,
	input logic                      cfg_ready,
	input logic [cta_pkg::CFG_W-1:0] cfg_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed before transfer");

	a_no_out_in_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.face_index <= cta_pkg::FACE_NEG_Z)
		else $error("face index out of range");

	a_zero_face: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.zero_vector |->
		out_data.face_index == cta_pkg::FACE_NEG_X &&
		out_data.texel_col == out_data.texel_row)
		else $error("zero vector result inconsistent");

endmodule

bind cubemap_texel_address cta_checker u_cta_checker (.*);

### tb/cubemap_texel_address_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubemap_texel_address_test
// Self-checking bench for the cube map texel address pipeline.
//
// Directions go in over valid/ready, and both sides add random gaps. Each
// result is checked field by field against a face and texel prediction made
// here for the current face_size. face_size is swept over its whole range,
// out-of-range codes included, between drained phases. One phase holds the
// output off long enough to fill the pipeline and stall the input.
// ----------------------------------------------------------------------------
module cubemap_texel_address_test;

	localparam int HALF_PERIOD  = 4;
	localparam int OUT_HOLD     = 300;
	localparam int WATCHDOG_MAX = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	cta_pkg::dir_t             in_data;
	logic                      out_valid;
	logic                      out_ready;
	cta_pkg::texel_t           out_data;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [cta_pkg::CFG_W-1:0] cfg_data;

	logic [cta_pkg::CFG_W-1:0] size_setting;
	cta_pkg::texel_t           expected_texels[$];
	int                        failures = 0;
	int                        quiet_cycles = 0;
	bit                        send_gaps;
	bit                        take_gaps;
	bit                        hold_output;

	cubemap_texel_address u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #HALF_PERIOD clk = ~clk;
	end

	function automatic longint texel_coord(input longint w, input longint ma, input longint sz);
		longint t;
		t = (w + ma) * sz / (2 * ma);
		return (t > sz - 1) ? sz - 1 : t;
	endfunction

	function automatic cta_pkg::texel_t texel_of_dir(input cta_pkg::dir_t d,
			input logic [cta_pkg::CFG_W-1:0] setting);
		longint x, y, z, ax, ay, az, ma, u, v, sz, col, row;
		logic [cta_pkg::FACE_W-1:0] face;
		logic zero;
		cta_pkg::texel_t r;
		x = longint'($signed(d.dir_x));
		y = longint'($signed(d.dir_y));
		z = longint'($signed(d.dir_z));
		ax = (x < 0) ? -x : x;
		ay = (y < 0) ? -y : y;
		az = (z < 0) ? -z : z;
		zero = (x == 0) && (y == 0) && (z == 0);
		sz = setting;
		if (sz == 0) begin
			sz = 1;
		end else if (sz > cta_pkg::MAX_FACE_SIZE) begin
			sz = cta_pkg::MAX_FACE_SIZE;
		end
		// major axis, ties go to X then Y; non-positive major picks the negative face
		if (ax >= ay && ax >= az) begin
			ma = ax;
			if (x > 0) begin
				face = cta_pkg::FACE_POS_X;
				u = -z;
				v = -y;
			end else begin
				face = cta_pkg::FACE_NEG_X;
				u = z;
				v = -y;
			end
		end else if (ay >= az) begin
			ma = ay;
			if (y > 0) begin
				face = cta_pkg::FACE_POS_Y;
				u = x;
				v = z;
			end else begin
				face = cta_pkg::FACE_NEG_Y;
				u = x;
				v = -z;
			end
		end else begin
			ma = az;
			if (z > 0) begin
				face = cta_pkg::FACE_POS_Z;
				u = x;
				v = -y;
			end else begin
				face = cta_pkg::FACE_NEG_Z;
				u = -x;
				v = -y;
			end
		end
		if (zero) begin
			col = sz - 1;
			row = sz - 1;
		end else begin
			col = texel_coord(u, ma, sz);
			row = texel_coord(v, ma, sz);
		end
		r.face_index    = face;
		r.texel_col     = cta_pkg::TEXEL_W'(col);
		r.texel_row     = cta_pkg::TEXEL_W'(row);
		r.element_index = cta_pkg::ELEM_W'((row * sz + col) * 3);
		r.zero_vector   = zero;
		return r;
	endfunction

	task automatic report_field(input string name, input logic [31:0] want, input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	task automatic check_texel(input cta_pkg::texel_t got);
		cta_pkg::texel_t want;
		if (expected_texels.size() == 0) begin
			failures++;
			$display("%0t: unexpected result, expected none actual %p", $time, got);
			return;
		end
		want = expected_texels.pop_front();
		if (got !== want) begin
			failures++;
			report_field("face_index", 32'(want.face_index), 32'(got.face_index));
			report_field("texel_col", 32'(want.texel_col), 32'(got.texel_col));
			report_field("texel_row", 32'(want.texel_row), 32'(got.texel_row));
			report_field("element_index", 32'(want.element_index),
				32'(got.element_index));
			report_field("zero_vector", 32'(want.zero_vector), 32'(got.zero_vector));
		end
	endtask

	// result check before the new expectation, so a same-cycle input never pairs up
	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			check_texel(out_data);
		end
		if (in_valid && in_ready) begin
			expected_texels.push_back(texel_of_dir(in_data, size_setting));
		end
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= WATCHDOG_MAX) begin
			$display("cubemap_texel_address_test failed");
			$finish;
		end
	end

	initial begin
		int unsigned gap;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_output) begin
				hold_output = 1'b0;
				out_ready <= 1'b0;
				repeat (OUT_HOLD) @(negedge clk);
			end
			gap = take_gaps ? $urandom_range(0, 15) : 0;
			if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	function automatic logic signed [cta_pkg::DIR_W-1:0] signed_mag(input int unsigned m);
		if (m >= 32768) begin
			return {1'b1, {(cta_pkg::DIR_W-1){1'b0}}};
		end
		return $urandom_range(0, 1) ? cta_pkg::DIR_W'(m) : cta_pkg::DIR_W'(-int'(m));
	endfunction

	function automatic logic signed [cta_pkg::DIR_W-1:0] edge_component();
		logic signed [cta_pkg::DIR_W-1:0] edges [8] =
			'{-32768, -32767, -16384, -1, 0, 1, 16384, 32767};
		return edges[$urandom_range(0, 7)];
	endfunction

	function automatic cta_pkg::dir_t random_dir();
		cta_pkg::dir_t d;
		int unsigned kind, major, axis;
		logic signed [cta_pkg::DIR_W-1:0] c [3];
		kind = $urandom_range(0, 9);
		major = $urandom_range(1, 32768);
		axis = $urandom_range(0, 2);
		case (kind)
			0, 1, 2: begin
				for (int i = 0; i < 3; i++) c[i] = cta_pkg::DIR_W'($urandom);
			end
			3: begin
				for (int i = 0; i < 3; i++) c[i] = signed_mag(major);
			end
			4: begin
				for (int i = 0; i < 3; i++) c[i] = signed_mag(major);
				c[axis] = signed_mag($urandom_range(0, major));
			end
			5: begin
				for (int i = 0; i < 3; i++) c[i] = edge_component();
			end
			6: begin
				for (int i = 0; i < 3; i++) c[i] = signed_mag($urandom_range(0, 3));
			end
			default: begin
				for (int i = 0; i < 3; i++) c[i] = signed_mag($urandom_range(0, major));
				c[axis] = signed_mag(major);
			end
		endcase
		d.dir_x = c[0];
		d.dir_y = c[1];
		d.dir_z = c[2];
		return d;
	endfunction

	// entered and left at a falling edge
	task automatic send_dir(input cta_pkg::dir_t d);
		int unsigned gap;
		gap = send_gaps ? $urandom_range(0, 15) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_data  <= d;
		in_valid <= 1'b1;
		do @(posedge clk); while (!(in_valid && in_ready));
		@(negedge clk);
	endtask

	task automatic send_xyz(input int x, input int y, input int z);
		cta_pkg::dir_t d;
		d.dir_x = cta_pkg::DIR_W'(x);
		d.dir_y = cta_pkg::DIR_W'(y);
		d.dir_z = cta_pkg::DIR_W'(z);
		send_dir(d);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (expected_texels.size() != 0) @(negedge clk);
	endtask

	task automatic write_face_size(input logic [cta_pkg::CFG_W-1:0] value);
		drain();
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		@(negedge clk);
		size_setting = value;
		cfg_valid <= 1'b0;
	endtask

	task automatic pick_idling();
		int unsigned mode;
		mode = $urandom_range(0, 3);
		send_gaps = mode[0];
		take_gaps = mode[1];
	endtask

	task automatic send_corners();
		send_xyz(0, 0, 0);
		send_xyz(16384, -16384, -16384);
		send_xyz(-32768, 32767, 32767);
		send_xyz(-32768, -32768, -32768);
		send_xyz(0, -32768, -32768);
	endtask

	task automatic test_directed_cases();
		send_gaps = 1'b0;
		take_gaps = 1'b0;
		send_corners();
		send_xyz(16384, 0, 0);
		send_xyz(-16384, 0, 0);
		send_xyz(0, 16384, 0);
		send_xyz(0, -16384, 0);
		send_xyz(0, 0, 16384);
		send_xyz(0, 0, -16384);
		send_xyz(32767, 32767, 32767);
		send_xyz(16384, 16384, 16384);
		send_xyz(100, -100, 50);
		send_xyz(10, 200, -200);
		send_xyz(10, -200, 200);
		send_xyz(32767, -32768, 0);
		send_xyz(1, 0, 0);
		send_xyz(0, 1, 0);
		send_xyz(0, 0, -1);
		send_xyz(1, -1, 1);
		send_xyz(-32768, 0, 0);
		send_xyz(12345, -23456, 7);
		drain();
	endtask

	task automatic test_face_size_sweep();
		logic [cta_pkg::CFG_W-1:0] sizes [10] = '{1, 4096, 0, 8191, 4097, 2, 3, 4095, 7, 640};
		foreach (sizes[i]) begin
			write_face_size(sizes[i]);
			pick_idling();
			send_corners();
			repeat (50) send_dir(random_dir());
		end
	endtask

	task automatic test_random_directions();
		repeat (10) begin
			if ($urandom_range(0, 7) == 0) begin
				write_face_size(cta_pkg::CFG_W'($urandom));
			end else begin
				write_face_size(cta_pkg::CFG_W'($urandom_range(1, cta_pkg::MAX_FACE_SIZE)));
			end
			repeat (3) begin
				pick_idling();
				repeat (32) send_dir(random_dir());
			end
		end
	endtask

	task automatic test_output_backpressure();
		drain();
		send_gaps   = 1'b0;
		take_gaps   = 1'b0;
		hold_output = 1'b1;
		repeat (150) send_dir(random_dir());
		drain();
	endtask

	initial begin
		in_valid     = 1'b0;
		in_data      = '0;
		cfg_valid    = 1'b0;
		cfg_data     = '0;
		size_setting = cta_pkg::FACE_SIZE_RST;
		send_gaps    = 1'b0;
		take_gaps    = 1'b0;
		hold_output  = 1'b0;
		#1 arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_face_size_sweep();
		test_random_directions();
		test_output_backpressure();

		drain();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (failures == 0 && expected_texels.size() == 0) begin
			$display("cubemap_texel_address_test passed");
		end else begin
			$display("cubemap_texel_address_test failed");
		end
		$finish;
	end

endmodule
